[design/cdq_pkg.sv]
package cdq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_HEAD = 3'd0,
        OP_PUSH_TAIL = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_POP_TAIL  = 3'd3,
        OP_PEEK_HEAD = 3'd4,
        OP_PEEK_TAIL = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } cdq_cmd_t;

    typedef struct packed {
        logic out_free;
    } cdq_stat_t;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 4;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 40;

endpackage

[design/cdq_ctrl.sv]
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  cdq_stat_t stat,
    output cdq_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // hold the result until the output register frees up
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/cdq_datapath.sv]
module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cdq_cmd_t              cmd,
    output cdq_stat_t             stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [VALUE_W-1:0] mem [DEPTH];

    op_t                op_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [AW-1:0]      head_reg;
    logic [AW-1:0]      head_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [VALUE_W-1:0] rd_data_reg;
    status_t            res_status_reg;
    logic               res_rd_ok_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    status_t       status_next;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] addr;
    logic          is_full;
    logic          is_empty;
    logic [SW-1:0] sum_hc;
    logic [SW-1:0] sum_tail;
    logic [AW-1:0] pos_hc;
    logic [AW-1:0] pos_tail;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [VALUE_W-1:0]  read_value;
    logic [CW+COUNT_W-1:0] count_ext;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign sum_hc   = SW'(head_reg) + SW'(count_reg);
    assign sum_tail = sum_hc - SW'(1);
    assign pos_hc   = (sum_hc >= SW'(DEPTH)) ? AW'(sum_hc - SW'(DEPTH)) : AW'(sum_hc);
    assign pos_tail = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH))
                                               : AW'(sum_tail);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    always_comb
    begin
        status_next = ST_OK;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        addr        = head_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        unique case (op_reg)
            OP_PUSH_HEAD:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    addr       = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_PUSH_TAIL:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    addr       = pos_hc;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP_HEAD:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    addr       = head_reg;
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_POP_TAIL:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    addr       = pos_tail;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_PEEK_HEAD:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                    addr  = head_reg;
                end
            end
            OP_PEEK_TAIL:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                    addr  = pos_tail;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op_t'(s_tuser[OP_W-1:0]);
            val_reg <= s_tdata[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[addr] <= val_reg;
        end
        if (cmd.exec && rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg <= status_next;
            res_rd_ok_reg  <= rd_en;
        end
    end

    assign read_value = res_rd_ok_reg ? rd_data_reg :
                        ((res_status_reg == ST_EMPTY) ? '1 : '0);
    assign count_ext  = {{COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= {is_full, is_empty, count_ext[COUNT_W-1:0],
                             res_status_reg, read_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

endmodule

[design/circular_deque_core.sv]
// Double-ended queue held in a ring of DEPTH 32-bit entries.
//
// Input channel (s_*): one word per operation. s_tuser[2:0] selects the
// operation (push head, push tail, pop head, pop tail, peek head, peek
// tail); s_tdata[31:0] is the value stored by a push.
// Output channel (m_*): one word per operation, carrying the value read,
// the status (ok, full, empty) and the entry count and empty/full flags as
// they stand after the operation.
//
// An accepted word is captured, then executed around the registered memory
// read, then loaded into the output register and shown on m_tvalid. The
// controller takes no new word until that capture / execute / load is done.
// s_tready is high while the controller is idle, also while an earlier
// result still waits in the output register.
//
// Reset clears the head index, the count and the output valid; entry
// contents stay unknown until pushed. When m_tready is low the result holds
// in the output register; one more word may be accepted and executed, and
// its result waits until the register drains.
module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] push_value
    input  logic [IN_USER_W-1:0]  s_tuser,   // [2:0] operation, [7:3] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] read_value, [33:32] status,
                                             // [37:34] entry_count, [38] is_empty,
                                             // [39] is_full
);

    cdq_cmd_t  cmd;
    cdq_stat_t stat;

    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[design/cdq_checker.sv]
module cdq_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [IN_USER_W-1:0]  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    localparam logic SMALL_DEPTH = (DEPTH < 16);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[38] && m_tdata[39]))
        else $error("empty and full flagged together");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] == ST_EMPTY) |->
            (m_tdata[31:0] == '1) && m_tdata[38])
        else $error("empty refusal without -1 or empty flag");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] == ST_FULL) |->
            (m_tdata[31:0] == '0) && m_tdata[39])
        else $error("full refusal without zero value or full flag");

    a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && SMALL_DEPTH |-> (m_tdata[38] == (m_tdata[37:34] == 4'd0)))
        else $error("empty flag disagrees with count");

endmodule

bind circular_deque_core cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);
